// ===== rtl/stok_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stok_pkg
// Types, token kind codes, byte codes and keyword table of the tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

    // default limit on source length; offsets saturate at min(limit, 65535)
    localparam int unsigned MAX_SOURCE_BYTES = 65536;

    // result queue: one item gives at most MAX_RES tokens
    localparam int unsigned MAX_RES  = 4;
    localparam int unsigned RES_AW   = $clog2(MAX_RES);
    localparam int unsigned QDEPTH   = 8;
    localparam int unsigned QAW      = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } src_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_line;
        logic [15:0] token_offset;
        logic [15:0] token_length;
        logic        last_result;
    } tok_t;

    // token kinds
    localparam logic [4:0] K_IDENT  = 5'd0;
    localparam logic [4:0] K_NUMBER = 5'd6;
    localparam logic [4:0] K_STRING = 5'd7;
    localparam logic [4:0] K_LPAREN = 5'd8;
    localparam logic [4:0] K_RPAREN = 5'd9;
    localparam logic [4:0] K_LBRACE = 5'd10;
    localparam logic [4:0] K_RBRACE = 5'd11;
    localparam logic [4:0] K_LBRACK = 5'd12;
    localparam logic [4:0] K_RBRACK = 5'd13;
    localparam logic [4:0] K_ASSIGN = 5'd14;
    localparam logic [4:0] K_EQEQ   = 5'd15;
    localparam logic [4:0] K_PLUS   = 5'd16;
    localparam logic [4:0] K_MINUS  = 5'd17;
    localparam logic [4:0] K_STAR   = 5'd18;
    localparam logic [4:0] K_SLASH  = 5'd19;
    localparam logic [4:0] K_EOF    = 5'd20;
    localparam logic [4:0] K_UNTERM = 5'd21;
    localparam logic [4:0] K_BAD    = 5'd22;

    // byte codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;

    // keywords fun, var, while, if, else: byte k of a keyword at bits [8k +: 8]
    localparam int unsigned NKW = 5;
    localparam logic [63:0] KW_TEXT [NKW] = '{
        {40'd0, "nuf"},
        {40'd0, "rav"},
        {24'd0, "elihw"},
        {48'd0, "fi"},
        {32'd0, "esle"}
    };
    localparam logic [15:0] KW_LEN [NKW] = '{16'd3, 16'd3, 16'd5, 16'd2, 16'd4};

endpackage

// ===== rtl/source_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: one source byte per transaction in, tokens out.
// ----------------------------------------------------------------------------
// Output: tokens of a byte are registered into the queue and appear on tok_* in order.
// Throughput: one byte per cycle while the 8-entry token queue has 4 free
//   entries (at most 4 tokens per byte); tokens leave one per cycle if !tok_stall.
// Reset: rst_n clears scanner state (line 1, offset 0, idle) and the queue;
//   the scanner also returns to that state after each end-of-input byte.
module source_tokenizer #(
    parameter int unsigned MAX_SOURCE_BYTES = stok_pkg::MAX_SOURCE_BYTES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            src_valid,
    output logic            src_stall,
    input  stok_pkg::src_t  src_data,
    output logic            tok_valid,
    input  logic            tok_stall,
    output stok_pkg::tok_t  tok_data
);

    localparam logic [15:0] POS_LIMIT =
        (MAX_SOURCE_BYTES < 65535) ? 16'(MAX_SOURCE_BYTES) : 16'hFFFF;
    localparam int unsigned QDEPTH = stok_pkg::QDEPTH;
    localparam int unsigned QAW    = stok_pkg::QAW;
    localparam int unsigned RES_AW = stok_pkg::RES_AW;
    localparam int unsigned MAX_RES = stok_pkg::MAX_RES;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDENT,
        ST_NUMBER,
        ST_NUMDOT,
        ST_FRACTION,
        ST_STRING,
        ST_EQUAL
    } mode_t;

    typedef struct packed {
        logic [1:0]     cnt;
        stok_pkg::tok_t a;
        stok_pkg::tok_t b;
    } flush_t;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [15:0] sat16(logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] sat_pos(logic [16:0] v);
        return (v > {1'b0, POS_LIMIT}) ? POS_LIMIT : v[15:0];
    endfunction

    function automatic stok_pkg::tok_t mk(logic [4:0] k, logic [15:0] ln,
                                          logic [15:0] off, logic [15:0] len,
                                          logic last);
        stok_pkg::tok_t t;
        t.token_kind   = k;
        t.token_line   = ln;
        t.token_offset = off;
        t.token_length = len;
        t.last_result  = last;
        return t;
    endfunction

    function automatic logic [4:0] first_hits(logic [7:0] c);
        logic [4:0] h;
        for (int i = 0; i < stok_pkg::NKW; i++)
        begin
            h[i] = (stok_pkg::KW_TEXT[i][7:0] == c);
        end
        return h;
    endfunction

    // drop keywords that the byte at index idx no longer matches
    function automatic logic [4:0] next_hits(logic [4:0] h, logic [15:0] idx,
                                             logic [7:0] c);
        logic [4:0] r;
        r = h;
        for (int i = 0; i < stok_pkg::NKW; i++)
        begin
            if (idx >= stok_pkg::KW_LEN[i])
                r[i] = 1'b0;
            else if (stok_pkg::KW_TEXT[i][{idx[2:0], 3'b000} +: 8] != c)
                r[i] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [4:0] ident_kind(logic [4:0] h, logic [15:0] s);
        logic [4:0] k;
        k = stok_pkg::K_IDENT;
        // lowest matching keyword wins
        for (int i = stok_pkg::NKW - 1; i >= 0; i--)
        begin
            if (h[i] && (s == stok_pkg::KW_LEN[i]))
                k = 5'(i + 1);
        end
        return k;
    endfunction

    function automatic logic [4:0] single_kind(logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            "(":     k = stok_pkg::K_LPAREN;
            ")":     k = stok_pkg::K_RPAREN;
            "{":     k = stok_pkg::K_LBRACE;
            "}":     k = stok_pkg::K_RBRACE;
            "[":     k = stok_pkg::K_LBRACK;
            "]":     k = stok_pkg::K_RBRACK;
            "+":     k = stok_pkg::K_PLUS;
            "-":     k = stok_pkg::K_MINUS;
            "*":     k = stok_pkg::K_STAR;
            "/":     k = stok_pkg::K_SLASH;
            default: k = stok_pkg::K_BAD;
        endcase
        return k;
    endfunction

    // token pending in a mode at a boundary
    function automatic flush_t flush_tok(mode_t m, logic [15:0] b, logic [15:0] s,
                                         logic [4:0] h, logic [15:0] ln,
                                         logic at_end);
        flush_t f;
        f = '0;
        unique case (m) inside
            ST_IDENT:
            begin
                f.cnt = 2'd1;
                f.a   = mk(ident_kind(h, s), ln, b, s, 1'b0);
            end
            ST_NUMBER, ST_FRACTION:
            begin
                f.cnt = 2'd1;
                f.a   = mk(stok_pkg::K_NUMBER, ln, b, s, 1'b0);
            end
            ST_NUMDOT:
            begin
                // lone dot after a number: number, then the dot as a bad byte
                f.cnt = 2'd2;
                f.a   = mk(stok_pkg::K_NUMBER, ln, b, s, 1'b0);
                f.b   = mk(stok_pkg::K_BAD, ln, sat_pos({1'b0, b} + {1'b0, s}),
                           16'd1, 1'b0);
            end
            ST_STRING:
            begin
                if (at_end)
                begin
                    f.cnt = 2'd1;
                    f.a   = mk(stok_pkg::K_UNTERM, ln, b, s, 1'b0);
                end
            end
            ST_EQUAL:
            begin
                f.cnt = 2'd1;
                f.a   = mk(stok_pkg::K_ASSIGN, ln, b, 16'd1, 1'b0);
            end
            default:
            begin
            end
        endcase
        return f;
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    mode_t       mode_reg,  mode_next;
    logic [15:0] line_reg,  line_next;
    logic [15:0] pos_reg,   pos_next;
    logic [15:0] begin_reg, begin_next;
    logic [15:0] size_reg,  size_next;
    logic [4:0]  hits_reg,  hits_next;

    logic [QAW-1:0] rd_reg,  rd_next;
    logic [QAW-1:0] wr_reg,  wr_next;
    logic [QAW:0]   cnt_reg, cnt_next;
    stok_pkg::tok_t q_reg [QDEPTH];

    logic           acc;
    logic           pop;
    logic [7:0]     ch;
    logic           eoi;
    logic           taken;
    logic [RES_AW:0] n;
    stok_pkg::tok_t res [MAX_RES];
    flush_t         fl_mid;
    flush_t         fl_end;
    logic [QAW-1:0] wr_off [QDEPTH];

    assign src_stall = (cnt_reg > (QAW+1)'(QDEPTH - MAX_RES));
    assign acc       = src_valid && !src_stall;
    assign tok_valid = (cnt_reg != '0);
    assign tok_data  = q_reg[rd_reg];
    assign pop       = tok_valid && !tok_stall;

    assign ch  = src_data.char_code;
    assign eoi = src_data.end_of_input;

    // ------------------------------------------------------------------
    // one byte of scanning
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        begin_next = begin_reg;
        size_next  = size_reg;
        hits_next  = hits_reg;
        taken      = 1'b0;
        n          = '0;
        fl_mid     = '0;
        fl_end     = '0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i] = '0;
        end

        // continue the current token
        unique case (mode_reg)
            ST_IDENT:
            begin
                if (is_alpha(ch) || is_digit(ch))
                begin
                    hits_next = next_hits(hits_reg, size_reg, ch);
                    size_next = sat16({1'b0, size_reg} + 17'd1);
                    taken     = 1'b1;
                end
            end
            ST_NUMBER:
            begin
                if (is_digit(ch))
                begin
                    size_next = sat16({1'b0, size_reg} + 17'd1);
                    taken     = 1'b1;
                end
                else if (ch == stok_pkg::CH_DOT)
                begin
                    mode_next = ST_NUMDOT;
                    taken     = 1'b1;
                end
            end
            ST_NUMDOT:
            begin
                if (is_digit(ch))
                begin
                    size_next = sat16({1'b0, size_reg} + 17'd2);
                    mode_next = ST_FRACTION;
                    taken     = 1'b1;
                end
            end
            ST_FRACTION:
            begin
                if (is_digit(ch))
                begin
                    size_next = sat16({1'b0, size_reg} + 17'd1);
                    taken     = 1'b1;
                end
            end
            ST_STRING:
            begin
                taken     = 1'b1;
                size_next = sat16({1'b0, size_reg} + 17'd1);
                if (ch == stok_pkg::CH_QUOTE)
                begin
                    res[n[RES_AW-1:0]] = mk(stok_pkg::K_STRING, line_reg, begin_reg,
                                            size_next, 1'b0);
                    n         = n + 1'b1;
                    mode_next = ST_IDLE;
                end
                else if (ch == stok_pkg::CH_LF)
                begin
                    line_next = sat16({1'b0, line_reg} + 17'd1);
                end
            end
            ST_EQUAL:
            begin
                if (ch == stok_pkg::CH_EQUAL)
                begin
                    res[n[RES_AW-1:0]] = mk(stok_pkg::K_EQEQ, line_reg, begin_reg,
                                            16'd2, 1'b0);
                    n         = n + 1'b1;
                    mode_next = ST_IDLE;
                    taken     = 1'b1;
                end
            end
            default:
            begin
                mode_next = ST_IDLE;
            end
        endcase

        // byte ends the current token: close it, then start a new one
        if (!taken)
        begin
            fl_mid = flush_tok(mode_next, begin_next, size_next, hits_next,
                               line_next, 1'b0);
            if (fl_mid.cnt != 2'd0)
            begin
                res[n[RES_AW-1:0]] = fl_mid.a;
                n = n + 1'b1;
            end
            if (fl_mid.cnt == 2'd2)
            begin
                res[n[RES_AW-1:0]] = fl_mid.b;
                n = n + 1'b1;
            end
            mode_next = ST_IDLE;

            if ((ch == stok_pkg::CH_SPACE) || (ch == stok_pkg::CH_TAB) ||
                (ch == stok_pkg::CH_CR))
            begin
            end
            else if (ch == stok_pkg::CH_LF)
            begin
                line_next = sat16({1'b0, line_next} + 17'd1);
            end
            else if (is_alpha(ch))
            begin
                mode_next  = ST_IDENT;
                begin_next = pos_reg;
                size_next  = 16'd1;
                hits_next  = first_hits(ch);
            end
            else if (is_digit(ch))
            begin
                mode_next  = ST_NUMBER;
                begin_next = pos_reg;
                size_next  = 16'd1;
            end
            else if (ch == stok_pkg::CH_QUOTE)
            begin
                mode_next  = ST_STRING;
                begin_next = pos_reg;
                size_next  = 16'd1;
            end
            else if (ch == stok_pkg::CH_EQUAL)
            begin
                mode_next  = ST_EQUAL;
                begin_next = pos_reg;
                size_next  = 16'd1;
            end
            else
            begin
                res[n[RES_AW-1:0]] = mk(single_kind(ch), line_next, pos_reg,
                                        16'd1, 1'b0);
                n = n + 1'b1;
            end
        end

        pos_next = sat_pos({1'b0, pos_reg} + 17'd1);

        // end of input: close what is open, EOF token, back to reset state
        if (eoi)
        begin
            fl_end = flush_tok(mode_next, begin_next, size_next, hits_next,
                               line_next, 1'b1);
            if (fl_end.cnt != 2'd0)
            begin
                res[n[RES_AW-1:0]] = fl_end.a;
                n = n + 1'b1;
            end
            if (fl_end.cnt == 2'd2)
            begin
                res[n[RES_AW-1:0]] = fl_end.b;
                n = n + 1'b1;
            end
            res[n[RES_AW-1:0]] = mk(stok_pkg::K_EOF, line_next, pos_next, 16'd0, 1'b1);
            n = n + 1'b1;

            mode_next  = ST_IDLE;
            line_next  = 16'd1;
            pos_next   = 16'd0;
            begin_next = 16'd0;
            size_next  = 16'd0;
            hits_next  = 5'd0;
        end
    end

    // ------------------------------------------------------------------
    // token queue pointers
    // ------------------------------------------------------------------
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (acc)
        begin
            wr_next  = wr_reg + QAW'(n);
            cnt_next = cnt_next + (QAW+1)'(n);
        end
        if (pop)
        begin
            rd_next  = rd_reg + 1'b1;
            cnt_next = cnt_next - 1'b1;
        end
        for (int i = 0; i < QDEPTH; i++)
        begin
            wr_off[i] = QAW'(i) - wr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ST_IDLE;
            line_reg  <= 16'd1;
            pos_reg   <= 16'd0;
            begin_reg <= 16'd0;
            size_reg  <= 16'd0;
            hits_reg  <= 5'd0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (acc)
            begin
                mode_reg  <= mode_next;
                line_reg  <= line_next;
                pos_reg   <= pos_next;
                begin_reg <= begin_next;
                size_reg  <= size_next;
                hits_reg  <= hits_next;
            end
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    // each entry takes the result whose rank matches its distance from the tail
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (acc && ((RES_AW+1)'(wr_off[i]) < n) && (wr_off[i] < QAW'(MAX_RES)))
                q_reg[i] <= res[wr_off[i][RES_AW-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QAW+1)'(QDEPTH))
        else $error("token queue count above depth");

    a_last_is_eof: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.last_result |-> tok_data.token_kind == stok_pkg::K_EOF)
        else $error("last token is not EOF");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> tok_data.token_line != 16'd0)
        else $error("token line is zero");

    a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
        acc && eoi |=> (mode_reg == ST_IDLE) && (line_reg == 16'd1) &&
                       (pos_reg == 16'd0))
        else $error("scanner not reset after end of input");
`endif

endmodule
